// ===== sv/tpr_pkg.sv =====
// tpr_pkg: shared types and constants for the token to page range lookup
// holds the transaction payload structs, state encoding and register map
// no dependencies
package tpr_pkg;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CNT_FIELD_W = 11;

  localparam logic [CFG_AW-1:0] ADDR_ENTRY_COUNT = 3'd0;

  typedef enum logic {
    FUNC_WRITE  = 1'b0,
    FUNC_LOOKUP = 1'b1
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [9:0]  entry_index;
    logic [31:0] entry_begin;
    logic [15:0] entry_tokens;
    logic [31:0] entry_page;
    logic [31:0] lookup_token;
  } in_data_t;

  typedef struct packed {
    logic        hit;
    logic [9:0]  hit_index;
    logic [31:0] hit_page;
    logic [31:0] hit_begin;
    logic [15:0] hit_tokens;
  } out_data_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CHK
  } state_t;

endpackage

// ===== sv/token_to_page_range_lookup_top.sv =====
// token_to_page_range_lookup_top: range table with binary search lookup
// one synchronous table memory (one read, one write port) plus the search sequencer
// depends on tpr_pkg
//
// usage:
//   command channel: present in_data with start high; the transaction is taken
//   at the clock edge where start is high and busy is low.
//   a write transaction (func 0) stores one entry in the cycle it is taken and
//   leaves busy low, so another transaction can follow in the next cycle.
//   a lookup transaction (func 1) raises busy and runs an upper-bound binary
//   search, one table probe per cycle; the probe count is at most ceil(log2(n+1))
//   for n = min(entry_count, MAX_ENTRIES), which is 11 for 1024 entries.
//   the result appears on out_data for one cycle with out_valid high, registered
//   from the check state that follows the search steps (on an empty table the
//   lookup goes straight to the check state). busy falls in the cycle the result
//   is shown, so a new transaction can be taken then.
//   the result receiver cannot stall; out_valid is a strobe.
//   configuration: apb port, entry_count at byte address 0; the user must write it
//   only while idle, which the block does not enforce; reads return its value.
//   reset clears entry_count, the sequencer and out_valid; table contents are
//   undefined until written.
module token_to_page_range_lookup_top
  import tpr_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES      = 1024,
  parameter int unsigned PAGE_HANDLE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_data_t          in_data,
  output logic              out_valid,
  output out_data_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned PW    = PAGE_HANDLE_BITS;
  localparam int unsigned RW    = 48 + PW;

  state_t state_r, state_nxt;

  logic [CNT_FIELD_W-1:0] count_r;
  logic [31:0]            token_r;
  logic [CNT_W-1:0]       first_r, first_nxt;
  logic [CNT_W-1:0]       len_r, len_nxt;
  logic                   out_valid_r;
  out_data_t              out_r, out_nxt;

  logic [RW-1:0] mem [MAX_ENTRIES];
  logic [RW-1:0] rdata_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [RW-1:0] wr_data;
  logic          mem_we;

  logic             take;
  logic             take_lookup;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] half;
  logic [CNT_W-1:0] probe;
  logic [CNT_W-1:0] cand;
  logic [31:0]      rd_begin;
  logic [15:0]      rd_tokens;
  logic [PW-1:0]    rd_page;
  logic [63:0]      page_in64;
  logic [63:0]      page_out64;
  logic [32:0]      range_end;
  logic             cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_ENTRY_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr) begin
      count_r <= pwdata[CNT_FIELD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_ENTRY_COUNT) begin
      prdata = 32'(count_r);
    end
  end

  // handshake
  assign busy        = (state_r != ST_IDLE);
  assign take        = start && !busy;
  assign take_lookup = take && (in_data.func == FUNC_LOOKUP);

  always_comb begin
    if (32'(count_r) > 32'(MAX_ENTRIES)) begin
      n_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      n_eff = CNT_W'(count_r);
    end
  end

  // table memory
  assign rd_begin  = rdata_r[RW-1 -: 32];
  assign rd_tokens = rdata_r[PW+15 -: 16];
  assign rd_page   = rdata_r[PW-1:0];
  assign page_in64  = {32'b0, in_data.entry_page};
  assign page_out64 = 64'(rd_page);

  assign wr_addr = AW'(in_data.entry_index);
  assign wr_data = {in_data.entry_begin, in_data.entry_tokens, page_in64[PW-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  // search step
  assign half  = len_r >> 1;
  assign probe = first_r + half;
  assign cand  = first_r - CNT_W'(1);
  assign range_end = {1'b0, rd_begin} + 33'(rd_tokens);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take_lookup) begin
          state_nxt = (n_eff == '0) ? ST_CHK : ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (len_nxt == '0) begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    mem_we    = 1'b0;
    first_nxt = first_r;
    len_nxt   = len_r;
    rd_addr   = AW'(probe);
    out_nxt   = '0;
    unique case (state_r)
      ST_IDLE: begin
        mem_we    = take && (in_data.func == FUNC_WRITE) &&
                    (32'(in_data.entry_index) < 32'(MAX_ENTRIES));
        first_nxt = '0;
        len_nxt   = n_eff;
        rd_addr   = AW'(n_eff >> 1);
      end
      ST_SRCH: begin
        if (!(token_r < rd_begin)) begin
          first_nxt = probe + CNT_W'(1);
          len_nxt   = len_r - half - CNT_W'(1);
        end else begin
          first_nxt = first_r;
          len_nxt   = half;
        end
        if (len_nxt != '0) begin
          rd_addr = AW'(first_nxt + (len_nxt >> 1));
        end else begin
          rd_addr = AW'(first_nxt - CNT_W'(1));
        end
      end
      ST_CHK: begin
        if ((first_r != '0) && ({1'b0, token_r} < range_end)) begin
          out_nxt.hit        = 1'b1;
          out_nxt.hit_index  = 10'(cand);
          out_nxt.hit_page   = page_out64[31:0];
          out_nxt.hit_begin  = rd_begin;
          out_nxt.hit_tokens = rd_tokens;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_CHK);
    end
  end

  always_ff @(posedge clk) begin
    if (take_lookup) begin
      token_r <= in_data.lookup_token;
    end
    if (state_r != ST_CHK) begin
      first_r <= first_nxt;
      len_r   <= len_nxt;
    end
    if (state_r == ST_CHK) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while sequencer busy");

  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    take_lookup |=> busy)
    else $error("lookup taken without raising busy");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (take && (in_data.func == FUNC_WRITE)) |=> (!out_valid_r && !busy))
    else $error("write transaction produced a result or stalled");

  a_srch_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SRCH) |-> (len_r != '0))
    else $error("search step with empty range");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.hit) |->
      ((out_r.hit_index == '0) && (out_r.hit_page == '0) &&
       (out_r.hit_begin == '0) && (out_r.hit_tokens == '0)))
    else $error("miss result carries nonzero fields");

endmodule

// ===== tb/sv/token_to_page_range_lookup_top_tb.sv =====
// token_to_page_range_lookup_top_tb: self-checking testbench for the range lookup table
// drives write and lookup transactions, programs entry_count over apb, predicts every result
// depends on tpr_pkg and token_to_page_range_lookup_top
module token_to_page_range_lookup_top_tb
  import tpr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TBL_DEPTH = 1024;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam logic [CFG_AW-1:0] ADDR_UNUSED = 3'd4;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_data_t          in_data = '0;
  logic              out_valid;
  out_data_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  token_to_page_range_lookup_top #(
    .MAX_ENTRIES      (TBL_DEPTH),
    .PAGE_HANDLE_BITS (32)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predicted table contents and register copy, updated as transactions are taken
  logic [31:0]            tbl_begin  [TBL_DEPTH];
  logic [15:0]            tbl_tokens [TBL_DEPTH];
  logic [31:0]            tbl_page   [TBL_DEPTH];
  logic [CNT_FIELD_W-1:0] cnt_reg = '0;

  // what the stimulus side has written so far, used to aim lookup tokens
  logic [31:0] plan_begin  [TBL_DEPTH];
  logic [15:0] plan_tokens [TBL_DEPTH];

  in_data_t    cmd_q[$];
  out_data_t   range_q[$];
  int unsigned gap_pct = 20;
  bit          in_fire = 1'b0;
  int unsigned items_queued = 0;
  int unsigned items_taken = 0;
  int unsigned n_writes = 0;
  int unsigned n_lookups = 0;
  int unsigned n_hits = 0;
  int unsigned n_cfg = 0;
  int unsigned mism_count = 0;
  int unsigned idle_cycles = 0;

  function automatic out_data_t lookup_expect(logic [31:0] tok);
    int unsigned n;
    int unsigned lo;
    int unsigned span;
    int unsigned half;
    int unsigned mid;
    logic [32:0] lim;
    out_data_t   r;
    n = (cnt_reg > TBL_DEPTH) ? TBL_DEPTH : cnt_reg;
    lo = 0;
    span = n;
    while (span > 0) begin
      half = span / 2;
      mid = lo + half;
      if (tok >= tbl_begin[mid]) begin
        lo = mid + 1;
        span = span - (half + 1);
      end else begin
        span = half;
      end
    end
    r = '0;
    if (lo > 0) begin
      lim = {1'b0, tbl_begin[lo-1]} + {17'b0, tbl_tokens[lo-1]};
      if ({1'b0, tok} < lim) begin
        r.hit        = 1'b1;
        r.hit_index  = 10'(lo - 1);
        r.hit_page   = tbl_page[lo-1];
        r.hit_begin  = tbl_begin[lo-1];
        r.hit_tokens = tbl_tokens[lo-1];
      end
    end
    return r;
  endfunction

  function automatic in_data_t rand_in();
    logic [127:0] raw;
    in_data_t     item;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    item = raw[$bits(in_data_t)-1:0];
    return item;
  endfunction

  task automatic report_mismatch(string what, string detail);
    mism_count++;
    if (mism_count <= 10) $display("MISMATCH %s: %s", what, detail);
  endtask

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || in_fire) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        start   <= 1'b1;
        in_data <= cmd_q.pop_front();
      end else begin
        start   <= 1'b0;
        in_data <= rand_in();
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    in_data_t  cmd;
    out_data_t want;
    in_fire = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        cmd = in_data;
        in_fire = 1'b1;
        items_taken++;
        if (cmd.func == FUNC_WRITE) begin
          tbl_begin[cmd.entry_index]  = cmd.entry_begin;
          tbl_tokens[cmd.entry_index] = cmd.entry_tokens;
          tbl_page[cmd.entry_index]   = cmd.entry_page;
          n_writes++;
        end else begin
          range_q.push_back(lookup_expect(cmd.lookup_token));
          n_lookups++;
        end
      end
      if (out_valid === 1'b1) begin
        if (range_q.size() == 0) begin
          report_mismatch("unexpected result", $sformatf("%p", out_data));
        end else begin
          want = range_q.pop_front();
          if (want.hit) n_hits++;
          if (out_data.hit !== want.hit || out_data.hit_index !== want.hit_index ||
              out_data.hit_page !== want.hit_page || out_data.hit_begin !== want.hit_begin ||
              out_data.hit_tokens !== want.hit_tokens) begin
            report_mismatch("lookup result", {
              $sformatf("expected hit=%0d idx=%0d page=%h begin=%h tokens=%h",
                        want.hit, want.hit_index, want.hit_page, want.hit_begin,
                        want.hit_tokens),
              $sformatf(", got hit=%0d idx=%0d page=%h begin=%h tokens=%h",
                        out_data.hit, out_data.hit_index, out_data.hit_page,
                        out_data.hit_begin, out_data.hit_tokens)});
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1 || (psel && penable && pready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  task automatic push_write(int unsigned idx, logic [31:0] b, logic [15:0] t, logic [31:0] p);
    in_data_t item;
    item = rand_in();
    item.func         = FUNC_WRITE;
    item.entry_index  = 10'(idx);
    item.entry_begin  = b;
    item.entry_tokens = t;
    item.entry_page   = p;
    cmd_q.push_back(item);
    items_queued++;
    plan_begin[idx]  = b;
    plan_tokens[idx] = t;
  endtask

  task automatic push_lookup(logic [31:0] tok);
    in_data_t item;
    item = rand_in();
    item.func         = FUNC_LOOKUP;
    item.lookup_token = tok;
    cmd_q.push_back(item);
    items_queued++;
  endtask

  function automatic logic [31:0] aim_token(int unsigned n);
    int unsigned slot;
    logic [31:0] b;
    logic [15:0] t;
    if (n == 0) return $urandom();
    if (n > TBL_DEPTH) n = TBL_DEPTH;
    slot = $urandom_range(0, n - 1);
    b = plan_begin[slot];
    t = plan_tokens[slot];
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        return (t == 0) ? b : b + $urandom_range(0, t - 1);
      end
      5: return b;
      6: return b + t;
      7: return b - 1;
      default: return $urandom();
    endcase
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (items_taken != items_queued || range_q.size() != 0 || busy !== 1'b0);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [CFG_AW-1:0] addr,
                          input logic [31:0] data, output logic [31:0] rd);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (pready !== 1'b1);
    rd = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_write(logic [CFG_AW-1:0] addr, logic [31:0] data);
    logic [31:0] rd;
    wait_idle();
    apb_xfer(1'b1, addr, data, rd);
    if (addr == ADDR_ENTRY_COUNT) cnt_reg = data[CNT_FIELD_W-1:0];
    n_cfg++;
    apb_xfer(1'b0, ADDR_ENTRY_COUNT, $urandom(), rd);
    if (rd[CNT_FIELD_W-1:0] !== cnt_reg) begin
      report_mismatch("entry_count readback",
                      $sformatf("expected %0d, got %0d", cnt_reg, rd[CNT_FIELD_W-1:0]));
    end
  endtask

  task automatic set_count(int unsigned v);
    cfg_write(ADDR_ENTRY_COUNT, ($urandom() & ~32'h7FF) | (v & 32'h7FF));
  endtask

  task automatic small_round(bit ordered);
    int unsigned n;
    logic [31:0] s;
    logic [15:0] t;
    n = $urandom_range(1, 16);
    set_count(n);
    s = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - 640 - $urandom_range(0, 64)
                                 : $urandom_range(0, 200);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: t = 16'h0;
        1: t = 16'hFFFF;
        default: t = 16'($urandom_range(1, 48));
      endcase
      push_write(i, ordered ? s : $urandom(), t, $urandom());
      s = s + $urandom_range(0, 40);
    end
    repeat ($urandom_range(4, 12)) begin
      if ($urandom_range(19) == 0) begin
        push_write($urandom_range(0, TBL_DEPTH - 1), $urandom(), 16'($urandom_range(0, 65535)),
                   $urandom());
      end else begin
        push_lookup(aim_token(n));
      end
    end
  endtask

  task automatic big_round(int unsigned n);
    set_count(n);
    repeat (8) push_lookup(aim_token(n));
  endtask

  initial begin : stim
    logic [31:0] s;
    int unsigned k;
    int unsigned rand_start;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset value readback, write to an unused address must be ignored
    cfg_write(ADDR_UNUSED, $urandom());
    push_lookup(32'h0);
    push_lookup(32'hFFFF_FFFF);

    // small sorted table: zero-length entry, full-width page, range crossing 2^32
    push_write(0, 32'h10, 16'h0, 32'h0);
    push_write(1, 32'h20, 16'h10, 32'hFFFF_FFFF);
    push_write(2, 32'h100, 16'hFFFF, 32'h1234_5678);
    push_write(3, 32'h8000_0000, 16'h1, 32'hA5A5_A5A5);
    push_write(4, 32'hFFFF_FFFF, 16'hFFFF, 32'h5A5A_5A5A);
    set_count(5);
    push_lookup(32'h0);
    push_lookup(32'h10);
    push_lookup(32'h20);
    push_lookup(32'h2F);
    push_lookup(32'h30);
    push_lookup(32'h100 + 32'hFFFE);
    push_lookup(32'h8000_0000);
    push_lookup(32'h8000_0001);
    push_lookup(32'hFFFF_FFFF);

    // fill every slot in ascending order, then search at, beyond and below full capacity
    gap_pct = 0;
    s = $urandom_range(0, 15);
    for (int i = 0; i < TBL_DEPTH; i++) begin
      push_write(i, (i == TBL_DEPTH - 1) ? 32'hFFFF_FFFF : s, 16'($urandom_range(0, 65535)),
                 $urandom());
      s = s + $urandom_range(0, 1 << 21);
    end
    big_round(TBL_DEPTH);
    big_round(2047);
    big_round(TBL_DEPTH - 1);
    big_round(1);

    gap_pct = 20;
    rand_start = items_queued;
    while (items_queued < rand_start + 200) begin
      k = $urandom_range(99);
      if (k < 70) begin
        small_round(1'b1);
      end else if (k < 80) begin
        small_round(1'b0);
      end else if (k < 92) begin
        big_round($urandom_range(17, TBL_DEPTH));
      end else begin
        case ($urandom_range(3))
          0: big_round(0);
          1: big_round(2047);
          default: big_round($urandom_range(TBL_DEPTH + 1, 2047));
        endcase
      end
      if ($urandom_range(15) == 0) cfg_write(ADDR_UNUSED, $urandom());
    end

    wait_idle();
    repeat (20) @(negedge clk);
    $display("covered %0d table writes and %0d lookups (%0d hits, %0d misses)",
             n_writes, n_lookups, n_hits, n_lookups - n_hits);
    $display("%0d register writes, table sizes from empty through full and past capacity",
             n_cfg);
    if (mism_count == 0 && range_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d results missing", mism_count, range_q.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== token_to_page_range_lookup_top.f =====
sv/tpr_pkg.sv
sv/token_to_page_range_lookup_top.sv
tb/sv/token_to_page_range_lookup_top_tb.sv
